[rtl/core/rgb565_blend_tint_key_pixel_defines.svh]
// ----------------------------------------------------------------------------
// rgb565_blend_tint_key_pixel_defines.svh
// Assertion macros used by the checker file of the pixel blender.
// ----------------------------------------------------------------------------
`ifndef RGB565_BLEND_TINT_KEY_PIXEL_DEFINES_SVH
`define RGB565_BLEND_TINT_KEY_PIXEL_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBTK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbtk: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RBTK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbtk: check failed");

`endif

[rtl/core/rbtk_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtk_pkg
// Types, constants and channel arithmetic for the RGB565 blender.
// ----------------------------------------------------------------------------
package rbtk_pkg;

  typedef logic [15:0] pixel_t;
  typedef logic [5:0]  chan_t;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] TINT_NONE    = 16'hFFFF;
  localparam chan_t       CH_MAX_RB    = 6'd31;
  localparam chan_t       CH_MAX_G     = 6'd63;
  localparam int          CFG_IDX_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA       = 3'd0,
    CFG_TINT        = 3'd1,
    CFG_MODE        = 3'd2,
    CFG_KEY         = 3'd3,
    CFG_SRC_INDEXED = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MODE_BLEND  = 3'd0,
    MODE_ADD    = 3'd1,
    MODE_SUB    = 3'd2,
    MODE_MUL    = 3'd3,
    MODE_SCREEN = 3'd4
  } blend_mode_e;

  typedef struct packed {
    chan_t       s;
    logic [13:0] sa;
    logic [13:0] dna;
    logic [13:0] d255;
    logic [11:0] ds;
    logic [11:0] scr;
  } chan_prod_t;

  // s * t / 32 (5-bit channel) or / 64 (6-bit channel), truncated
  function automatic chan_t tint_chan(chan_t s, chan_t t, logic wide);
    logic [11:0] p;
    p = 12'(s) * 12'(t);
    return wide ? p[11:6] : {1'b0, p[9:5]};
  endfunction

  function automatic chan_prod_t mk_prod(chan_t s, chan_t d, logic [7:0] a, logic wide);
    chan_prod_t r;
    chan_t      mx;
    mx     = wide ? CH_MAX_G : CH_MAX_RB;
    r.s    = s;
    r.sa   = 14'(s) * 14'(a);
    r.dna  = 14'(d) * 14'(ALPHA_OPAQUE - a);
    r.d255 = (14'(d) << 8) - 14'(d);
    r.ds   = 12'(d) * 12'(s);
    r.scr  = 12'(mx - d) * 12'(mx - s);
    return r;
  endfunction

  function automatic chan_t mix_chan(chan_prod_t p, logic [2:0] mode, logic opaque,
                                     logic wide);
    logic [14:0] sum;
    logic [13:0] diff;
    chan_t       mx;
    chan_t       q;
    chan_t       res;
    mx   = wide ? CH_MAX_G : CH_MAX_RB;
    sum  = 15'(p.sa) + 15'(p.d255);
    diff = p.d255 - p.sa;
    q    = wide ? p.scr[11:6] : {1'b0, p.scr[9:5]};
    res  = p.s;
    case (mode)
      MODE_BLEND: begin
        if (!opaque) begin
          res = 6'((15'(p.sa) + 15'(p.dna)) >> 8);
        end
      end
      MODE_ADD: begin
        res = (sum[14:8] > 7'(mx)) ? mx : sum[13:8];
      end
      MODE_SUB: begin
        res = (p.d255 <= p.sa) ? 6'd0 : diff[13:8];
      end
      MODE_MUL: begin
        res = wide ? p.ds[11:6] : {1'b0, p.ds[9:5]};
      end
      MODE_SCREEN: begin
        res = mx - q;
      end
      default: begin
        res = p.s;
      end
    endcase
    return res;
  endfunction

endpackage

[rtl/core/rbtk_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtk_if
// Valid/ready channels of the RGB565 blender: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface rbtk_in_if;
  logic            valid;
  logic            ready;
  rbtk_pkg::pixel_t src_pixel;
  rbtk_pkg::pixel_t dst_pixel;
  logic            line_end;

  modport source (output valid, output src_pixel, output dst_pixel, output line_end,
                  input ready);
  modport sink   (input valid, input src_pixel, input dst_pixel, input line_end,
                  output ready);
endinterface

interface rbtk_out_if;
  logic            valid;
  logic            ready;
  rbtk_pkg::pixel_t out_pixel;
  logic            write_enable;
  logic            line_end_out;

  modport source (output valid, output out_pixel, output write_enable,
                  output line_end_out, input ready);
  modport sink   (input valid, input out_pixel, input write_enable,
                  input line_end_out, output ready);
endinterface

interface rbtk_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rbtk_pkg::CFG_IDX_W-1:0]    index;
  logic [15:0]                       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/rgb565_blend_tint_key_pixel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_blend_tint_key_pixel
// RGB565 pixel blender with tint, five blend modes and color key.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one word per pixel: source, destination, line end marker.
//   out_o : one word per pixel: result pixel, write enable, line end.
//   cfg_i : register writes (0 alpha, 1 tint, 2 mode, 3 key, 4 src indexed),
//           always ready; write only while no pixel is in flight.
//   Three register stages: tint, channel products, mix/clamp/select.
//   Throughput is one pixel per clock while out_o stays ready, set by the
//   stage handshake.
//   A keyed pixel comes out with write enable low and the destination pixel.
//   Reset empties the pipeline and loads alpha 255, tint 0xFFFF, mode 0,
//   key 0, source not indexed.
//   When out_o stalls, each stage holds only if the stage after it is full,
//   so bubbles are squeezed out and in_i stays ready until all three
//   stages hold a word.
// ----------------------------------------------------------------------------
module rgb565_blend_tint_key_pixel (
  input  logic        clk_i,
  input  logic        rst_ni,
  rbtk_in_if.sink     in_i,
  rbtk_out_if.source  out_o,
  rbtk_cfg_if.sink    cfg_i
);
  import rbtk_pkg::*;

  typedef struct packed {
    pixel_t src;
    pixel_t dst;
    chan_t  r;
    chan_t  g;
    chan_t  b;
    logic   copy;
    logic   skip;
    logic   le;
  } st1_t;

  typedef struct packed {
    pixel_t     src;
    pixel_t     dst;
    chan_prod_t pr;
    chan_prod_t pg;
    chan_prod_t pb;
    logic       copy;
    logic       skip;
    logic       le;
  } st2_t;

  logic [7:0]  alpha_q;
  pixel_t      tint_q;
  logic [2:0]  mode_q;
  pixel_t      key_q;
  logic        idx_q;

  logic        v1_q, v2_q, v3_q;
  logic        en1, en2, en3;
  st1_t        s1_d, s1_q;
  st2_t        s2_d, s2_q;
  pixel_t      pix_d, pix_q;
  logic        we_q, le_q;

  logic        copy_c, keyoff_c, tinted_c;
  chan_t       sr, sg, sb;
  chan_t       mr, mg, mb;

  // config registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_OPAQUE;
      tint_q  <= TINT_NONE;
      mode_q  <= MODE_BLEND;
      key_q   <= '0;
      idx_q   <= 1'b0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ALPHA:       alpha_q <= cfg_i.data[7:0];
        CFG_TINT:        tint_q  <= cfg_i.data;
        CFG_MODE:        mode_q  <= cfg_i.data[2:0];
        CFG_KEY:         key_q   <= cfg_i.data;
        CFG_SRC_INDEXED: idx_q   <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign en3        = !v3_q || out_o.ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: key decision and tint
  assign copy_c   = (alpha_q == ALPHA_OPAQUE) && (tint_q == TINT_NONE);
  assign tinted_c = (tint_q != TINT_NONE);
  assign keyoff_c = ((key_q == 16'd0) && !idx_q) || ((key_q == 16'd1) && idx_q);
  assign sr       = {1'b0, in_i.src_pixel[4:0]};
  assign sg       = in_i.src_pixel[10:5];
  assign sb       = {1'b0, in_i.src_pixel[15:11]};

  always_comb begin
    s1_d      = '0;
    s1_d.src  = in_i.src_pixel;
    s1_d.dst  = in_i.dst_pixel;
    s1_d.copy = copy_c;
    s1_d.le   = in_i.line_end;
    s1_d.skip = copy_c ? (!keyoff_c && (in_i.src_pixel == key_q))
                       : ((key_q != 16'd0) && (in_i.src_pixel == key_q));
    s1_d.r    = tinted_c ? tint_chan(sr, {1'b0, tint_q[4:0]}, 1'b0) : sr;
    s1_d.g    = tinted_c ? tint_chan(sg, tint_q[10:5], 1'b1) : sg;
    s1_d.b    = tinted_c ? tint_chan(sb, {1'b0, tint_q[15:11]}, 1'b0) : sb;
  end

  // stage 2: channel products
  always_comb begin
    s2_d      = '0;
    s2_d.src  = s1_q.src;
    s2_d.dst  = s1_q.dst;
    s2_d.copy = s1_q.copy;
    s2_d.skip = s1_q.skip;
    s2_d.le   = s1_q.le;
    s2_d.pr   = mk_prod(s1_q.r, {1'b0, s1_q.dst[4:0]}, alpha_q, 1'b0);
    s2_d.pg   = mk_prod(s1_q.g, s1_q.dst[10:5], alpha_q, 1'b1);
    s2_d.pb   = mk_prod(s1_q.b, {1'b0, s1_q.dst[15:11]}, alpha_q, 1'b0);
  end

  // stage 3: mix, clamp, select
  assign mr = mix_chan(s2_q.pr, mode_q, alpha_q == ALPHA_OPAQUE, 1'b0);
  assign mg = mix_chan(s2_q.pg, mode_q, alpha_q == ALPHA_OPAQUE, 1'b1);
  assign mb = mix_chan(s2_q.pb, mode_q, alpha_q == ALPHA_OPAQUE, 1'b0);

  always_comb begin
    if (s2_q.skip) begin
      pix_d = s2_q.dst;
    end else if (s2_q.copy) begin
      pix_d = s2_q.src;
    end else begin
      pix_d = {mb[4:0], mg, mr[4:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) begin
      pix_q <= pix_d;
      we_q  <= !s2_q.skip;
      le_q  <= s2_q.le;
    end
  end

  assign out_o.valid        = v3_q;
  assign out_o.out_pixel    = pix_q;
  assign out_o.write_enable = we_q;
  assign out_o.line_end_out = le_q;

endmodule

[rtl/core/rbtk_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbtk_checker
// Port-level checks of the RGB565 blender, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgb565_blend_tint_key_pixel_defines.svh"

module rbtk_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input rbtk_pkg::pixel_t     out_pixel_i,
  input logic                 write_enable_i,
  input logic                 line_end_out_i
);

  // a stalled result word holds
  `RBTK_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_pixel_i) && $stable(write_enable_i) && $stable(line_end_out_i))

  // a free output keeps the input open
  `RBTK_ASSERT_NOW(a_in_open, out_ready_i, in_ready_i)

  // an accepted word comes out valid when the output drains meanwhile
  `RBTK_ASSERT_NEXT(a_latency, in_valid_i && in_ready_i ##1 out_ready_i ##1 out_ready_i, out_valid_i)

  // pipeline comes out of reset empty
  `RBTK_ASSERT_NOW(a_reset_empty, $rose(rst_ni), !out_valid_i)

endmodule

bind rgb565_blend_tint_key_pixel rbtk_checker u_rbtk_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_pixel_i    (out_o.out_pixel),
  .write_enable_i (out_o.write_enable),
  .line_end_out_i (out_o.line_end_out)
);

[dv/rgb565_blend_tint_key_pixel_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_blend_tint_key_pixel_test
// Self-checking bench for the RGB565 blender. Pixel words go in with random
// gaps while the output side stalls at random. Each accepted word is run
// through a local model of the copy path, the tint, the five mix modes and
// the color key. Result words are checked in order, field by field.
// ----------------------------------------------------------------------------
module rgb565_blend_tint_key_pixel_test;
  import rbtk_pkg::*;

  typedef struct packed {
    pixel_t pix;
    logic   we;
    logic   le;
  } px_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rbtk_in_if  in_if ();
  rbtk_out_if out_if ();
  rbtk_cfg_if cfg_if ();

  rgb565_blend_tint_key_pixel uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  logic [7:0]  cur_alpha   = ALPHA_OPAQUE;
  logic [15:0] cur_tint    = TINT_NONE;
  logic [2:0]  cur_mode    = MODE_BLEND;
  logic [15:0] cur_key     = 16'h0000;
  logic        cur_indexed = 1'b0;

  px_word_t pending_px[$];
  int       errors = 0;
  int       items_sent = 0;
  int       words_checked = 0;
  int       keyed_skips = 0;
  int       reg_writes = 0;
  bit       idle_en = 1'b1;
  bit       hold_req = 1'b0;
  int       hold_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL rgb565_blend_tint_key_pixel");
    $finish;
  end

  // one 5- or 6-bit channel after tint; mx is the channel max, dv its divisor
  function automatic int unsigned combine_chan(int unsigned s, int unsigned d,
                                               int unsigned mx, int unsigned dv);
    int unsigned v;
    case (cur_mode)
      MODE_BLEND: begin
        v = (cur_alpha < 255) ? (s * cur_alpha + d * (255 - cur_alpha)) / 256 : s;
      end
      MODE_ADD: begin
        v = (s * cur_alpha + d * 255) / 256;
        if (v > mx) v = mx;
      end
      MODE_SUB: begin
        v = (d * 255 <= s * cur_alpha) ? 0 : (d * 255 - s * cur_alpha) / 256;
      end
      MODE_MUL: begin
        v = d * s / dv;
      end
      MODE_SCREEN: begin
        v = mx - (mx - d) * (mx - s) / dv;
        if (v > mx) v = mx;
      end
      default: begin
        v = s;
      end
    endcase
    return v;
  endfunction

  function automatic px_word_t blend_predict(pixel_t src, pixel_t dst, logic le);
    px_word_t    r;
    bit          key_off;
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    r.le  = le;
    r.we  = 1'b1;
    r.pix = src;
    if (cur_alpha == ALPHA_OPAQUE && cur_tint == TINT_NONE) begin
      key_off = (cur_key == 16'h0000 && !cur_indexed) ||
                (cur_key == 16'h0001 && cur_indexed);
      if (!key_off && src == cur_key) r.we = 1'b0;
    end else if (cur_key != 16'h0000 && src == cur_key) begin
      r.we = 1'b0;
    end else begin
      sr = src[4:0];
      sg = src[10:5];
      sb = src[15:11];
      if (cur_tint != TINT_NONE) begin
        sr = sr * cur_tint[4:0] / 32;
        sg = sg * cur_tint[10:5] / 64;
        sb = sb * cur_tint[15:11] / 32;
      end
      sr = combine_chan(sr, dst[4:0], 31, 32);
      sg = combine_chan(sg, dst[10:5], 63, 64);
      sb = combine_chan(sb, dst[15:11], 31, 32);
      r.pix = {sb[4:0], sg[5:0], sr[4:0]};
    end
    if (!r.we) r.pix = dst;
    return r;
  endfunction

  task automatic push_pixel(pixel_t src, pixel_t dst, logic le);
    int gap;
    gap = (idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid     <= 1'b1;
    in_if.src_pixel <= src;
    in_if.dst_pixel <= dst;
    in_if.line_end  <= le;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_px.push_back(blend_predict(src, dst, le));
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_ALPHA:       cur_alpha   = val[7:0];
      CFG_TINT:        cur_tint    = val;
      CFG_MODE:        cur_mode    = val[2:0];
      CFG_KEY:         cur_key     = val;
      CFG_SRC_INDEXED: cur_indexed = val[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_settings(logic [15:0] a, logic [15:0] t, logic [15:0] m,
                               logic [15:0] k, logic [15:0] ix);
    write_reg(CFG_ALPHA, a);
    write_reg(CFG_TINT, t);
    write_reg(CFG_MODE, m);
    write_reg(CFG_KEY, k);
    write_reg(CFG_SRC_INDEXED, ix);
  endtask

  // drain: all expected words out, then a short wait for stray words
  task automatic settle();
    int n;
    @(negedge clk);
    in_if.valid <= 1'b0;
    n = 0;
    while (pending_px.size() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
    if (pending_px.size() != 0) begin
      $display("%0t ns: %0d words never came out", $time, pending_px.size());
      errors++;
      pending_px.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  function automatic pixel_t pick_src();
    case ($urandom_range(0, 7))
      0: return cur_key;
      1: return 16'h0000;
      2: return 16'hFFFF;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  function automatic pixel_t pick_dst();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return pixel_t'($urandom);
    endcase
  endfunction

  task automatic run_stream(int count);
    int i;
    for (i = 0; i < count; i++) begin
      push_pixel(pick_src(), pick_dst(), logic'($urandom_range(0, 15) == 0));
    end
  endtask

  // alpha, mode and src indexed writes get random upper bits; only the low bits count
  task automatic random_settings(int ph);
    logic [7:0]  a;
    logic [15:0] t;
    logic [15:0] k;
    logic [2:0]  m;
    case ($urandom_range(0, 5))
      0: a = 8'd0;
      1: a = 8'd1;
      2: a = 8'd254;
      3: a = ALPHA_OPAQUE;
      default: a = 8'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: t = TINT_NONE;
      1: t = 16'h0000;
      2: t = 16'hFFFE;
      default: t = 16'($urandom);
    endcase
    if (ph % 5 == 4) begin
      a = ALPHA_OPAQUE;
      t = TINT_NONE;
    end
    m = 3'(ph % 8);
    case ($urandom_range(0, 4))
      0: k = 16'h0000;
      1: k = 16'h0001;
      2: k = 16'hFFFF;
      default: k = 16'($urandom);
    endcase
    load_settings({8'($urandom), a}, t, {13'($urandom), m}, k,
                  {15'($urandom), 1'($urandom)});
  endtask

  task automatic test_copy_keying();
    load_settings(16'h00FF, TINT_NONE, MODE_BLEND, 16'h0000, 16'h0000);
    push_pixel(16'h0000, 16'hABCD, 1'b0);
    push_pixel(16'hFFFF, 16'h0000, 1'b1);
    settle();
    write_reg(CFG_KEY, 16'h1234);
    push_pixel(16'h1234, 16'h5555, 1'b0);
    push_pixel(16'h1235, 16'hAAAA, 1'b1);
    settle();
    // key 1 on an indexed source means no keying
    write_reg(CFG_KEY, 16'h0001);
    write_reg(CFG_SRC_INDEXED, 16'h0001);
    push_pixel(16'h0001, 16'h7777, 1'b0);
    settle();
    write_reg(CFG_KEY, 16'h0000);
    push_pixel(16'h0000, 16'h8888, 1'b1);
    settle();
    write_reg(CFG_KEY, 16'h0001);
    write_reg(CFG_SRC_INDEXED, 16'h0000);
    push_pixel(16'h0001, 16'hFFFF, 1'b0);
    settle();
  endtask

  task automatic test_mode_extremes();
    int m;
    load_settings(16'h0080, TINT_NONE, MODE_BLEND, 16'h0000, 16'h0000);
    for (m = 0; m < 8; m++) begin
      write_reg(CFG_MODE, 16'(m));
      push_pixel(16'hFFFF, 16'h0000, m[0]);
      if (m <= MODE_SCREEN) push_pixel(16'h0000, 16'hFFFF, !m[0]);
      settle();
    end
    // opaque alpha with a tint goes through the mixing path
    load_settings(16'h00FF, 16'h8410, MODE_ADD, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'h1234, 1'b0);
    settle();
    load_settings(16'h0000, TINT_NONE, MODE_BLEND, 16'h0000, 16'h0000);
    push_pixel(16'hFFFF, 16'h0000, 1'b1);
    settle();
    load_settings(16'd100, TINT_NONE, MODE_SUB, 16'h1234, 16'h0000);
    push_pixel(16'h1234, 16'h4321, 1'b0);
    push_pixel(16'h0000, 16'hFFFF, 1'b1);
    settle();
    write_reg(CFG_KEY, 16'h0000);
    push_pixel(16'h0000, 16'h5A5A, 1'b0);
    settle();
  endtask

  task automatic test_random_settings();
    int ph;
    for (ph = 0; ph < 14; ph++) begin
      random_settings(ph);
      run_stream(100);
      settle();
    end
  endtask

  task automatic test_stall_fill();
    random_settings(2);
    idle_en     = 1'b0;
    hold_cycles = 80;
    hold_req    = 1'b1;
    run_stream(60);
    settle();
    idle_en = 1'b1;
  endtask

  task automatic test_steady_stream();
    random_settings($urandom_range(0, 13));
    idle_en = 1'b0;
    run_stream(240);
    settle();
  endtask

  initial begin : out_sink
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) stall_left--;
      if (stall_left == 0) begin
        if (hold_req) begin
          stall_left = hold_cycles;
          hold_req   = 1'b0;
        end else if (idle_en && $urandom_range(0, 11) == 0) begin
          stall_left = $urandom_range(1, 15);
        end
      end
      out_if.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin : out_check
    px_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_px.size() == 0) begin
        $display("%0t ns: word with nothing expected, actual pixel %h we %b le %b",
                 $time, out_if.out_pixel, out_if.write_enable, out_if.line_end_out);
        errors++;
      end else begin
        w = pending_px.pop_front();
        words_checked++;
        if (!out_if.write_enable) keyed_skips++;
        if (out_if.out_pixel !== w.pix) begin
          $display("%0t ns: out_pixel expected %h actual %h", $time, w.pix,
                   out_if.out_pixel);
          errors++;
        end
        if (out_if.write_enable !== w.we) begin
          $display("%0t ns: write_enable expected %b actual %b", $time, w.we,
                   out_if.write_enable);
          errors++;
        end
        if (out_if.line_end_out !== w.le) begin
          $display("%0t ns: line_end_out expected %b actual %b", $time, w.le,
                   out_if.line_end_out);
          errors++;
        end
      end
    end
  end

  initial begin
    in_if.valid     = 1'b0;
    in_if.src_pixel = 16'h0000;
    in_if.dst_pixel = 16'h0000;
    in_if.line_end  = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = CFG_ALPHA;
    cfg_if.data     = 16'h0000;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_copy_keying();
    test_mode_extremes();
    test_random_settings();
    test_stall_fill();
    test_steady_stream();

    $display("Covered copy and mixing paths, all eight mode codes, keying and a full stall:");
    $display("%0d pixel words in, %0d checked, %0d keyed, %0d register writes",
             items_sent, words_checked, keyed_skips, reg_writes);
    if (errors == 0) begin
      $display("PASS rgb565_blend_tint_key_pixel");
    end else begin
      $display("FAIL rgb565_blend_tint_key_pixel");
    end
    $finish;
  end

endmodule

[rgb565_blend_tint_key_pixel.f]
+incdir+rtl/core
rtl/core/rbtk_pkg.sv
rtl/core/rbtk_if.sv
rtl/core/rgb565_blend_tint_key_pixel.sv
rtl/core/rbtk_checker.sv
dv/rgb565_blend_tint_key_pixel_test.sv
